// ===== rtl/core/cfs_pkg.sv =====
// Package for the Cholesky factor-and-solve block: payload types, codes, constants.
// No dependencies.
package cfs_pkg;

    localparam int MAX_ORDER_DEF = 8;
    localparam int MAX_RHS_DEF   = 8;

    localparam logic [1:0] KIND_LOAD_A = 2'd0;
    localparam logic [1:0] KIND_LOAD_B = 2'd1;
    localparam logic [1:0] KIND_START  = 2'd2;

    localparam logic REG_ORDER = 1'b0;
    localparam logic REG_RHS   = 1'b1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  row;
        logic [2:0]  col;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  out_row;
        logic [2:0]  out_col;
        logic signed [31:0] solution;
        logic        failed;
        logic        last;
    } out_item_t;

    // request to the shared divide / square-root unit
    typedef struct packed {
        logic        start;
        logic        is_sqrt;
        logic signed [31:0] num;
        logic [31:0] den;
    } du_req_t;

    typedef struct packed {
        logic        done;
        logic signed [31:0] res;
    } du_rsp_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

endpackage

// ===== rtl/core/cfs_divsqrt.sv =====
// Shared multi-cycle unit: restoring divide (a*2^16)/d and bit-pair square root.
// Depends on cfs_pkg.
module cfs_divsqrt (
    input  logic            clk,
    input  logic            rst_n,
    input  cfs_pkg::du_req_t req,
    output cfs_pkg::du_rsp_t rsp
);
    import cfs_pkg::*;

    logic        busy_reg, busy_next;
    logic        sq_reg, sq_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [47:0] num_reg, num_next;
    logic [48:0] rem_reg, rem_next;
    logic [47:0] quo_reg, quo_next;
    logic [31:0] den_reg, den_next;
    logic        done_reg, done_next;
    logic signed [31:0] res_reg, res_next;

    logic [31:0] amag;
    logic [48:0] trial;
    logic [49:0] srem;
    logic [49:0] strial;
    logic signed [63:0] sres;

    always_comb
    begin
        amag = req.num[31] ? 32'(-req.num) : req.num;
        busy_next = busy_reg;
        sq_next = sq_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        num_next = num_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        den_next = den_reg;
        done_next = 1'b0;
        res_next = res_reg;
        trial = '0;
        srem = '0;
        strial = '0;
        sres = '0;
        if (!busy_reg) begin
            if (req.start) begin
                busy_next = 1'b1;
                sq_next = req.is_sqrt;
                neg_next = req.num[31];
                num_next = {amag, 16'd0};
                den_next = req.den;
                rem_next = '0;
                quo_next = '0;
                cnt_next = req.is_sqrt ? 6'd24 : 6'd48;
            end
        end else if (cnt_reg != 6'd0) begin
            cnt_next = cnt_reg - 6'd1;
            if (sq_reg) begin
                // two radicand bits per step
                srem = {rem_reg[47:0], num_reg[47:46]};
                strial = {quo_reg[47:0], 2'b01};
                num_next = {num_reg[45:0], 2'b00};
                if (srem >= strial) begin
                    rem_next = 49'(srem - strial);
                    quo_next = {quo_reg[46:0], 1'b1};
                end else begin
                    rem_next = srem[48:0];
                    quo_next = {quo_reg[46:0], 1'b0};
                end
            end else begin
                trial = {rem_reg[47:0], num_reg[47]};
                num_next = {num_reg[46:0], 1'b0};
                if (trial >= {17'd0, den_reg}) begin
                    rem_next = trial - {17'd0, den_reg};
                    quo_next = {quo_reg[46:0], 1'b1};
                end else begin
                    rem_next = trial;
                    quo_next = {quo_reg[46:0], 1'b0};
                end
            end
        end else begin
            busy_next = 1'b0;
            done_next = 1'b1;
            sres = $signed({16'd0, quo_reg});
            if (neg_reg && !sq_reg)
                sres = -sres;
            res_next = sat32(sres);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg <= sq_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        num_reg <= num_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        res_reg <= res_next;
    end

    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("done held");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy_reg) |-> $past(req.start)) else $error("spurious busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg)) else $error("done without busy");

endmodule

// ===== rtl/core/cholesky_factor_and_solve.sv =====
// Cholesky factor-and-solve top level: memories, sequencer, output register.
// Depends on cfs_pkg and cfs_divsqrt.
// Loads are taken only while the sequencer is idle and no result waits in the
// output register. A start stalls input for the whole solve: about n^3/6 + m*n^2
// multiply-accumulate steps (two memory reads, one multiply register) plus the
// divides and square roots. Results pass a buffer read, then the output register.
// Reset clears the control state only; the stores hold garbage until loaded.
module cholesky_factor_and_solve #(
    parameter int MAX_ORDER = cfs_pkg::MAX_ORDER_DEF,
    parameter int MAX_RHS   = cfs_pkg::MAX_RHS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  cfs_pkg::in_item_t in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output cfs_pkg::out_item_t out_data,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [3:0]        cfg_data
);
    import cfs_pkg::*;

    localparam int AW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int BW = (MAX_RHS > 1) ? $clog2(MAX_RHS) : 1;
    localparam int AD = MAX_ORDER * MAX_ORDER;
    localparam int BD = MAX_ORDER * MAX_RHS;
    localparam int AAW = $clog2(AD) > 0 ? $clog2(AD) : 1;
    localparam int BAW = $clog2(BD) > 0 ? $clog2(BD) : 1;

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FINIT = 4'd1;  // read s = A(i,j)
    localparam logic [3:0] S_FRD   = 4'd2;  // read A(i,k-1),A(j,k-1) or start divide / sqrt
    localparam logic [3:0] S_FMUL  = 4'd3;  // multiply
    localparam logic [3:0] S_FACC  = 4'd4;  // subtract
    localparam logic [3:0] S_FDIV  = 4'd5;  // wait divide / sqrt
    localparam logic [3:0] S_SINIT = 4'd6;
    localparam logic [3:0] S_SRD   = 4'd7;
    localparam logic [3:0] S_SMUL  = 4'd8;
    localparam logic [3:0] S_SACC  = 4'd9;
    localparam logic [3:0] S_SDIV  = 4'd10;
    localparam logic [3:0] S_EMIT  = 4'd11;
    localparam logic [3:0] S_FAIL  = 4'd12;
    localparam logic [3:0] S_LOAD  = 4'd13; // capture initial read

    logic [3:0] order_reg, rhs_reg;
    logic [3:0] st_reg, st_next;
    logic [AW:0] n_eff, i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [BW:0] m_eff, c_reg, c_next;
    logic        bwd_reg, bwd_next;   // backward substitution pass
    logic [3:0]  ret_reg, ret_next;   // state after S_LOAD; pending-read flag in S_EMIT
    logic signed [31:0] s_reg, s_next;
    logic signed [31:0] p_reg, p_next;
    logic signed [31:0] d_reg, d_next;

    // memories
    logic signed [31:0] amem [AD];
    logic signed [31:0] bmem [BD];
    logic signed [31:0] dmem [MAX_ORDER];
    logic [AAW-1:0] a_ra0, a_ra1, a_wa;
    logic [BAW-1:0] b_ra, b_wa;
    logic [AW-1:0]  d_ra, d_wa;
    logic           a_we, b_we, d_we;
    logic signed [31:0] a_wd, b_wd, d_wd;
    logic signed [31:0] a_q0, a_q1, b_q, d_q;

    du_req_t req;
    du_rsp_t rsp;
    cfs_divsqrt u_du (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    logic        ov_reg, ov_next;
    out_item_t   od_reg, od_next;

    logic signed [63:0] prod;
    logic [63:0] pm;
    logic signed [63:0] diff;
    logic in_acc;

    function automatic logic [AAW-1:0] aidx(input logic [AW:0] r, input logic [AW:0] c);
        logic [31:0] t;
        t = 32'(r[AW-1:0]) * 32'(MAX_ORDER) + 32'(c[AW-1:0]);
        return t[AAW-1:0];
    endfunction

    function automatic logic [BAW-1:0] bidx(input logic [AW:0] r, input logic [BW:0] c);
        logic [31:0] t;
        t = 32'(r[AW-1:0]) * 32'(MAX_RHS) + 32'(c[BW-1:0]);
        return t[BAW-1:0];
    endfunction

    always_comb
    begin
        if (order_reg == 4'd0)
            n_eff = (AW+1)'(1);
        else if (32'(order_reg) > MAX_ORDER)
            n_eff = (AW+1)'(MAX_ORDER);
        else
            n_eff = (AW+1)'(order_reg);
        if (rhs_reg == 4'd0)
            m_eff = (BW+1)'(1);
        else if (32'(rhs_reg) > MAX_RHS)
            m_eff = (BW+1)'(MAX_RHS);
        else
            m_eff = (BW+1)'(rhs_reg);
    end

    assign in_stall = (st_reg != S_IDLE) || ov_reg;
    assign in_acc   = in_valid && !in_stall;

    // Q15.16 product on registered operands
    always_comb
    begin
        logic [31:0] ma, mb;
        ma = a_q0[31] ? 32'(-a_q0) : a_q0;
        mb = (st_reg == S_SMUL) ? (b_q[31] ? 32'(-b_q) : b_q)
                                : (a_q1[31] ? 32'(-a_q1) : a_q1);
        pm = 64'(ma) * 64'(mb) >> 16;
        prod = $signed(pm);
        if (a_q0[31] != ((st_reg == S_SMUL) ? b_q[31] : a_q1[31]))
            prod = -prod;
        diff = 64'(s_reg) - 64'(p_reg);
    end

    always_comb
    begin
        st_next = st_reg;
        i_next = i_reg; j_next = j_reg; k_next = k_reg; c_next = c_reg;
        bwd_next = bwd_reg; ret_next = ret_reg;
        s_next = s_reg; p_next = p_reg; d_next = d_reg;
        ov_next = ov_reg; od_next = od_reg;
        a_ra0 = '0; a_ra1 = '0; a_wa = '0; a_we = 1'b0; a_wd = '0;
        b_ra = '0; b_wa = '0; b_we = 1'b0; b_wd = '0;
        d_ra = i_reg[AW-1:0]; d_wa = i_reg[AW-1:0]; d_we = 1'b0; d_wd = rsp.res;
        req = '0;
        if (ov_reg && !out_stall)
            ov_next = 1'b0;
        case (st_reg)
            S_IDLE:
            begin
                if (in_acc) begin
                    if (in_data.kind == KIND_LOAD_A && 32'(in_data.row) < MAX_ORDER
                        && 32'(in_data.col) < MAX_ORDER) begin
                        a_we = 1'b1;
                        a_wa = aidx((AW+1)'(in_data.row), (AW+1)'(in_data.col));
                        a_wd = in_data.value;
                    end else if (in_data.kind == KIND_LOAD_B && 32'(in_data.row) < MAX_ORDER
                        && 32'(in_data.col) < MAX_RHS) begin
                        b_we = 1'b1;
                        b_wa = bidx((AW+1)'(in_data.row), (BW+1)'(in_data.col));
                        b_wd = in_data.value;
                    end else if (in_data.kind == KIND_START) begin
                        i_next = '0; j_next = '0;
                        st_next = S_FINIT;
                    end
                end
            end
            S_FINIT:
            begin
                a_ra0 = aidx(i_reg, j_reg);
                k_next = i_reg;
                ret_next = S_FRD;
                st_next = S_LOAD;
            end
            S_LOAD:
            begin
                s_next = (ret_reg == S_FRD) ? a_q0 : b_q;
                d_next = d_q;
                st_next = ret_reg;
            end
            S_FRD:
            begin
                if (k_reg == '0) begin
                    if (i_reg == j_reg) begin
                        if (s_reg <= 0) begin
                            st_next = S_FAIL;
                        end else begin
                            req.start = 1'b1; req.is_sqrt = 1'b1; req.num = s_reg;
                            st_next = S_FDIV;
                        end
                    end else begin
                        req.start = 1'b1; req.num = s_reg; req.den = d_reg;
                        st_next = S_FDIV;
                    end
                end else begin
                    a_ra0 = aidx(i_reg, k_reg - 1'b1);
                    a_ra1 = aidx(j_reg, k_reg - 1'b1);
                    k_next = k_reg - 1'b1;
                    st_next = S_FMUL;
                end
            end
            S_FMUL:
            begin
                p_next = sat32(prod);
                st_next = S_FACC;
            end
            S_FACC:
            begin
                s_next = sat32(diff);
                st_next = S_FRD;
            end
            S_FDIV:
            begin
                if (rsp.done) begin
                    if (i_reg == j_reg) begin
                        d_we = 1'b1;
                    end else begin
                        a_we = 1'b1;
                        a_wa = aidx(j_reg, i_reg);
                        a_wd = rsp.res;
                    end
                    // diagonal read must see fresh sqrt: reload via S_LOAD
                    if (j_reg + 1'b1 < n_eff) begin
                        j_next = j_reg + 1'b1;
                        st_next = S_FINIT;
                    end else if (i_reg + 1'b1 < n_eff) begin
                        i_next = i_reg + 1'b1;
                        j_next = i_reg + 1'b1;
                        st_next = S_FINIT;
                    end else begin
                        c_next = '0; i_next = '0; bwd_next = 1'b0;
                        st_next = S_SINIT;
                    end
                end
            end
            S_SINIT:
            begin
                b_ra = bidx(i_reg, c_reg);
                k_next = bwd_reg ? n_eff - 1'b1 : '0;
                ret_next = S_SRD;
                st_next = S_LOAD;
            end
            S_SRD:
            begin
                if ((!bwd_reg && k_reg == i_reg) || (bwd_reg && k_reg == i_reg)) begin
                    req.start = 1'b1; req.num = s_reg; req.den = d_reg;
                    st_next = S_SDIV;
                end else begin
                    a_ra0 = bwd_reg ? aidx(k_reg, i_reg) : aidx(i_reg, k_reg);
                    b_ra = bidx(k_reg, c_reg);
                    k_next = bwd_reg ? k_reg - 1'b1 : k_reg + 1'b1;
                    st_next = S_SMUL;
                end
            end
            S_SMUL:
            begin
                p_next = sat32(prod);
                st_next = S_SACC;
            end
            S_SACC:
            begin
                s_next = sat32(diff);
                st_next = S_SRD;
            end
            S_SDIV:
            begin
                if (rsp.done) begin
                    b_we = 1'b1;
                    b_wa = bidx(i_reg, c_reg);
                    b_wd = rsp.res;
                    if (!bwd_reg) begin
                        if (i_reg + 1'b1 < n_eff) begin
                            i_next = i_reg + 1'b1;
                        end else begin
                            bwd_next = 1'b1;
                        end
                        st_next = S_SINIT;
                    end else if (i_reg != '0) begin
                        i_next = i_reg - 1'b1;
                        st_next = S_SINIT;
                    end else begin
                        st_next = S_EMIT;
                        ret_next = S_IDLE;
                    end
                end
            end
            S_EMIT:
            begin
                // ret_reg marks a pending read (read issued, data next cycle);
                // the address is held so b_q stays put while the output waits
                b_ra = bidx(i_reg, c_reg);
                if (ret_reg == S_IDLE) begin
                    ret_next = S_EMIT;
                end else if (!ov_reg || !out_stall) begin
                    ov_next = 1'b1;
                    od_next.out_row = 3'(i_reg);
                    od_next.out_col = 3'(c_reg);
                    od_next.solution = b_q;
                    od_next.failed = 1'b0;
                    od_next.last = (c_reg + 1'b1 == m_eff) && (i_reg + 1'b1 == n_eff);
                    ret_next = S_IDLE;
                    if (i_reg + 1'b1 < n_eff) begin
                        i_next = i_reg + 1'b1;
                    end else begin
                        i_next = '0;
                        if (c_reg + 1'b1 < m_eff) begin
                            c_next = c_reg + 1'b1;
                            bwd_next = 1'b0;
                            st_next = S_SINIT;
                        end else begin
                            st_next = S_IDLE;
                        end
                    end
                end
            end
            S_FAIL:
            begin
                if (!ov_reg || !out_stall) begin
                    ov_next = 1'b1;
                    od_next.out_row = 3'(i_reg);
                    od_next.out_col = '0;
                    od_next.solution = '0;
                    od_next.failed = 1'b1;
                    od_next.last = 1'b1;
                    st_next = S_IDLE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    // synchronous memories with registered read data
    always_ff @(posedge clk)
    begin
        if (a_we)
            amem[a_wa] <= a_wd;
        a_q0 <= amem[a_ra0];
        a_q1 <= amem[a_ra1];
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
            bmem[b_wa] <= b_wd;
        b_q <= bmem[b_ra];
    end

    always_ff @(posedge clk)
    begin
        if (d_we)
            dmem[d_wa] <= d_wd;
        d_q <= dmem[d_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            order_reg <= 4'd8;
            rhs_reg <= 4'd1;
            st_reg <= S_IDLE;
            ov_reg <= 1'b0;
            ret_reg <= S_IDLE;
        end else begin
            if (cfg_we && cfg_index == REG_ORDER)
                order_reg <= cfg_data;
            if (cfg_we && cfg_index == REG_RHS)
                rhs_reg <= cfg_data;
            st_reg <= st_next;
            ov_reg <= ov_next;
            ret_reg <= ret_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg <= i_next; j_reg <= j_next; k_reg <= k_next; c_reg <= c_next;
        bwd_reg <= bwd_next;
        s_reg <= s_next; p_reg <= p_next; d_reg <= d_next;
        od_reg <= od_next;
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    a_idle_only_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> st_reg == S_IDLE) else $error("input taken while busy");
    a_fail_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.failed |-> out_data.last) else $error("fail not last");
    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) && out_data.last |-> st_reg == S_IDLE)
        else $error("last before end");

endmodule

// ===== tb/tb_cholesky_factor_and_solve.sv =====
// Testbench for cholesky_factor_and_solve: directed and random load/solve transactions,
// checked against a bit-accurate Q15.16 predictor held in a small scoreboard class.
// Depends on cfs_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_cholesky_factor_and_solve;
    import cfs_pkg::*;

    // kind 3 has no meaning in the block; it must be ignored
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int         ITEM_TARGET = 190;

    // Scoreboard: private copy of the block's stores and registers, plus the
    // queue of solution transactions still to come out of the block.
    class solve_scoreboard;
        int             a_mem [64];
        int             d_mem [8];
        int             b_mem [64];
        logic [3:0]     order_reg;
        logic [3:0]     rhs_reg;
        out_item_t      pending_q [$];
        int             errors;

        function new();
            foreach (a_mem[i]) a_mem[i] = 0;
            foreach (b_mem[i]) b_mem[i] = 0;
            foreach (d_mem[i]) d_mem[i] = 0;
            order_reg = 4'd8;
            rhs_reg   = 4'd1;
            errors    = 0;
        endfunction

        function void write_reg(logic idx, logic [3:0] val);
            if (idx == REG_ORDER)
                order_reg = val;
            else
                rhs_reg = val;
        endfunction

        function int clip32(longint v);
            if (v > 64'sd2147483647)
                return 32'sh7fffffff;
            if (v < -64'sd2147483648)
                return 32'sh80000000;
            return int'(v);
        endfunction

        function longint absval(int v);
            longint t;
            t = v;
            return (t < 0) ? -t : t;
        endfunction

        // truncating Q15.16 multiply, sign applied to the magnitude product
        function int fx_mul(int a, int b);
            longint r;
            r = (absval(a) * absval(b)) >>> 16;
            if ((a < 0) != (b < 0))
                r = -r;
            return clip32(r);
        endfunction

        function int fx_div(int a, int d);
            longint r;
            r = (absval(a) <<< 16) / absval(d);
            if ((a < 0) != (d < 0))
                r = -r;
            return clip32(r);
        endfunction

        function int fx_sub(int a, int b);
            return clip32(longint'(a) - longint'(b));
        endfunction

        // bitwise integer square root of s * 2^16
        function int fx_sqrt(int s);
            longint unsigned x;
            longint unsigned res;
            longint unsigned bitv;
            x    = longint'(s) <<< 16;
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > x)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (x >= res + bitv)
                begin
                    x   = x - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                    res = res >> 1;
                bitv = bitv >> 2;
            end
            return int'(res);
        endfunction

        function int clamp_size(logic [3:0] v);
            if (v == 0)
                return 1;
            if (v > 8)
                return 8;
            return int'(v);
        endfunction

        // factor, then forward and backward substitution per rhs column
        function void factor_and_solve();
            int n;
            int m;
            int s;
            out_item_t e;
            n = clamp_size(order_reg);
            m = clamp_size(rhs_reg);
            for (int i = 0; i < n; i++)
                for (int j = i; j < n; j++)
                begin
                    s = a_mem[i*8 + j];
                    for (int k = i; k > 0; k--)
                        s = fx_sub(s, fx_mul(a_mem[i*8 + k-1], a_mem[j*8 + k-1]));
                    if (i == j)
                    begin
                        if (s <= 0)
                        begin
                            e.out_row  = i[2:0];
                            e.out_col  = 3'd0;
                            e.solution = 32'sd0;
                            e.failed   = 1'b1;
                            e.last     = 1'b1;
                            pending_q.insert(pending_q.size(), e);
                            return;
                        end
                        d_mem[i] = fx_sqrt(s);
                    end
                    else
                        a_mem[j*8 + i] = fx_div(s, d_mem[i]);
                end
            for (int k = 0; k < m; k++)
            begin
                for (int i = 0; i < n; i++)
                begin
                    s = b_mem[i*8 + k];
                    for (int j = 0; j < i; j++)
                        s = fx_sub(s, fx_mul(a_mem[i*8 + j], b_mem[j*8 + k]));
                    b_mem[i*8 + k] = fx_div(s, d_mem[i]);
                end
                for (int r = n-1; r >= 0; r--)
                begin
                    s = b_mem[r*8 + k];
                    for (int j = n-1; j > r; j--)
                        s = fx_sub(s, fx_mul(a_mem[j*8 + r], b_mem[j*8 + k]));
                    b_mem[r*8 + k] = fx_div(s, d_mem[r]);
                end
                for (int i = 0; i < n; i++)
                begin
                    e.out_row  = i[2:0];
                    e.out_col  = k[2:0];
                    e.solution = b_mem[i*8 + k];
                    e.failed   = 1'b0;
                    e.last     = (k == m-1) && (i == n-1);
                    pending_q.insert(pending_q.size(), e);
                end
            end
        endfunction

        function void note_input(in_item_t it);
            case (it.kind)
                KIND_LOAD_A: a_mem[it.row*8 + it.col] = it.value;
                KIND_LOAD_B: b_mem[it.row*8 + it.col] = it.value;
                KIND_START:  factor_and_solve();
                default:     ;
            endcase
        endfunction

        function void check_result(out_item_t got);
            out_item_t e;
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result, actual %h", $time, got);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (got.out_row !== e.out_row)
            begin
                $display("%0t: out_row expected %0d actual %0d", $time, e.out_row, got.out_row);
                errors++;
            end
            if (got.out_col !== e.out_col)
            begin
                $display("%0t: out_col expected %0d actual %0d", $time, e.out_col, got.out_col);
                errors++;
            end
            if (got.solution !== e.solution)
            begin
                $display("%0t: solution expected %h actual %h", $time, e.solution, got.solution);
                errors++;
            end
            if (got.failed !== e.failed)
            begin
                $display("%0t: failed expected %b actual %b", $time, e.failed, got.failed);
                errors++;
            end
            if (got.last !== e.last)
            begin
                $display("%0t: last expected %b actual %b", $time, e.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    in_item_t   in_data;
    logic       out_valid;
    logic       out_stall;
    out_item_t  out_data;
    logic       cfg_we;
    logic       cfg_index;
    logic [3:0] cfg_data;

    solve_scoreboard sb;
    int  items_sent;
    bit  no_gaps;     // set for stretches with back-to-back transactions

    cholesky_factor_and_solve dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Called at a rising edge. Holds the payload until the block takes it; the
    // stall is sampled at the falling edge so there is no race with the DUT.
    task automatic send_item(in_item_t it);
        bit took;
        int g;
        in_valid <= 1'b1;
        in_data  <= it;
        do
        begin
            @(negedge clk);
            took = !in_stall;
            @(posedge clk);
        end
        while (!took);
        sb.note_input(it);
        items_sent++;
        g = no_gaps ? 0 : pick_gap();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic send_fields(logic [1:0] kind, int r, int c, logic [31:0] v);
        in_item_t it;
        it.kind  = kind;
        it.row   = r[2:0];
        it.col   = c[2:0];
        it.value = v;
        send_item(it);
    endtask

    // Sender pauses until every queued result has drained, then lets the
    // block settle before any register write.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_sizes(logic [3:0] ord, logic [3:0] rhs);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ORDER;
        cfg_data  <= ord;
        @(posedge clk);
        cfg_index <= REG_RHS;
        cfg_data  <= rhs;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.write_reg(REG_ORDER, ord);
        sb.write_reg(REG_RHS, rhs);
        @(posedge clk);
    endtask

    function automatic logic [31:0] signed_rand(int span);
        return $urandom_range(0, 2*span) - span;
    endfunction

    // Loads a diagonally dominant upper triangle and an rhs block in shuffled
    // order, with noise transactions mixed in, then starts the solve.
    // With break_it set, one pivot is made non-positive.
    task automatic load_and_solve(int n, int m, bit break_it);
        int          pos [$];
        int          t;
        int          sw;
        int          r;
        int          c;
        int          bad_row;
        logic [31:0] v;
        for (int i = 0; i < n; i++)
            for (int j = i; j < n; j++)
                pos.insert(pos.size(), i*8 + j);
        for (int k = 0; k < m; k++)
            for (int i = 0; i < n; i++)
                pos.insert(pos.size(), 64 + i*8 + k);
        for (int i = pos.size()-1; i > 0; i--)
        begin
            sw = $urandom_range(0, i);
            t = pos[i];
            pos[i] = pos[sw];
            pos[sw] = t;
        end
        bad_row = $urandom_range(0, n-1);
        foreach (pos[p])
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                // noise: ignored kind, lower-triangle junk, or an rhs entry in a spare column or column 0
                case ($urandom_range(0, 2))
                    0: send_fields(KIND_UNUSED, $urandom_range(0, 7), $urandom_range(0, 7),
                                   $urandom);
                    1: begin
                        r = $urandom_range(1, 7);
                        send_fields(KIND_LOAD_A, r, $urandom_range(0, r-1), $urandom);
                    end
                    default: send_fields(KIND_LOAD_B, $urandom_range(0, 7),
                                         $urandom_range(m, 8) % 8, $urandom);
                endcase
            end
            if (pos[p] >= 64)
            begin
                r = (pos[p] - 64) / 8;
                c = (pos[p] - 64) % 8;
                v = ($urandom_range(0, 9) == 0) ? $urandom : signed_rand(1 << 24);
                send_fields(KIND_LOAD_B, r, c, v);
            end
            else
            begin
                r = pos[p] / 8;
                c = pos[p] % 8;
                if (r != c)
                    v = signed_rand(1 << 17);
                else if (break_it && r == bad_row)
                    v = -$urandom_range(0, 1 << 20);
                else
                    v = $urandom_range(16 << 16, 1000 << 16);
                send_fields(KIND_LOAD_A, r, c, v);
            end
        end
        send_fields(KIND_START, $urandom_range(0, 7), $urandom_range(0, 7), $urandom);
    endtask

    // receiver stall: bursts of ready, then stalls mostly short, a few long
    initial
    begin
        int len;
        out_stall = 1'b0;
        forever
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 12);
            repeat (len) @(posedge clk) out_stall <= 1'b0;
            len = pick_gap();
            repeat (len) @(posedge clk) out_stall <= 1'b1;
        end
    end

    // result monitor: decide at the falling edge, retire at the rising edge
    initial
    begin
        out_item_t got;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got = out_data;
                @(posedge clk);
                sb.check_result(got);
            end
        end
    end

    initial
    begin
        int n;
        int m;
        logic [3:0] ord;
        logic [3:0] rhs;
        sb         = new();
        items_sent = 0;
        no_gaps    = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_we     = 1'b0;
        cfg_index  = REG_ORDER;
        cfg_data   = 4'd0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: size one through the zero order setting, full rhs width
        // via an over-range count, extreme entry values.
        set_sizes(4'd0, 4'd15);
        send_fields(KIND_LOAD_A, 0, 0, 32'h7fffffff);
        send_fields(KIND_LOAD_A, 7, 0, 32'h80000000);   // lower triangle, never read
        for (int k = 0; k < 8; k++)
            send_fields(KIND_LOAD_B, 0, k, (k == 0) ? 32'h7fffffff :
                        (k == 1) ? 32'h80000000 : (k == 2) ? 32'h0 : $urandom);
        send_fields(KIND_UNUSED, 7, 7, 32'hffffffff);
        send_fields(KIND_START, 0, 0, 32'h0);
        // zero pivot on row 0
        send_fields(KIND_LOAD_A, 0, 0, 32'h0);
        send_fields(KIND_START, 7, 7, 32'hffffffff);
        drain_results();
        // negative pivot on row 1: [1 2; 2 1]
        set_sizes(4'd2, 4'd1);
        send_fields(KIND_LOAD_A, 0, 0, 32'h00010000);
        send_fields(KIND_LOAD_A, 0, 1, 32'h00020000);
        send_fields(KIND_LOAD_A, 1, 1, 32'h00010000);
        send_fields(KIND_LOAD_B, 0, 0, 32'h00010000);
        send_fields(KIND_LOAD_B, 1, 0, 32'hffff0000);
        send_fields(KIND_START, 0, 0, 32'h0);
        drain_results();

        // Random phases: mostly small sizes, the extremes now and then.
        while (items_sent < ITEM_TARGET)
        begin
            case ($urandom_range(0, 9))
                0: ord = 4'd0;
                1: ord = 4'd15;
                2: ord = 4'd8;
                default: ord = 4'($urandom_range(1, 5));
            endcase
            case ($urandom_range(0, 9))
                0: rhs = 4'd0;
                1: rhs = 4'd15;
                2: rhs = 4'd8;
                default: rhs = 4'($urandom_range(1, 3));
            endcase
            set_sizes(ord, rhs);
            n = sb.clamp_size(ord);
            m = sb.clamp_size(rhs);
            no_gaps = ($urandom_range(0, 3) == 0);
            load_and_solve(n, m, $urandom_range(0, 5) == 0);
            // start again on the previous solution
            if ($urandom_range(0, 3) == 0)
                send_fields(KIND_START, 0, 0, $urandom);
            drain_results();
        end

        repeat (100) @(posedge clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // run limit: far beyond the slowest legal run
    initial
    begin
        #40ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== cholesky_factor_and_solve.f =====
rtl/core/cfs_pkg.sv
rtl/core/cfs_divsqrt.sv
rtl/core/cholesky_factor_and_solve.sv
tb/tb_cholesky_factor_and_solve.sv
